FILE: hdl/twvw_pkg.sv
package twvw_pkg;

   // payload widths
   localparam int PIX_W    = 24;
   localparam int REGION_W = 2;

   // configuration field widths
   localparam int POS_W    = 17;
   localparam int BORDER_W = 16;
   localparam int DIM_W    = 13;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_START_POS     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_END_POS       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BORDER_WIDTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SYMMETRIC     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VERTICAL      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BORDER_COLOUR = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd7;

   // region codes
   localparam logic [REGION_W-1:0] REGION_B      = 2'd0;
   localparam logic [REGION_W-1:0] REGION_A      = 2'd1;
   localparam logic [REGION_W-1:0] REGION_BORDER = 2'd2;

   // register reset values
   localparam logic [POS_W-1:0]    RST_START_POS     = 17'd43691;
   localparam logic [POS_W-1:0]    RST_END_POS       = 17'd21845;
   localparam logic [BORDER_W-1:0] RST_BORDER_WIDTH  = 16'd0;
   localparam logic                RST_SYMMETRIC     = 1'b1;
   localparam logic                RST_VERTICAL      = 1'b0;
   localparam logic [PIX_W-1:0]    RST_BORDER_COLOUR = 24'd0;
   localparam logic [DIM_W-1:0]    RST_LINE_WIDTH    = 13'd640;
   localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT  = 13'd480;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_a;
      logic [PIX_W-1:0] pixel_b;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel_out;
      logic [REGION_W-1:0] region;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]    start_pos;
      logic [POS_W-1:0]    end_pos;
      logic [BORDER_W-1:0] border_width;
      logic                symmetric;
      logic                vertical;
      logic [PIX_W-1:0]    border_colour;
      logic [DIM_W-1:0]    line_width;
      logic [DIM_W-1:0]    frame_height;
   } cfg_type;

endpackage

FILE: hdl/twvw_csr.sv
module twvw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [twvw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [twvw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [twvw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output twvw_pkg::cfg_type                   cfg
);

   twvw_pkg::cfg_type                 cfg_ff;
   logic [twvw_pkg::REG_IDX_W-1:0]    idx;
   logic                              wr_en;

   assign idx    = paddr[twvw_pkg::CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pos     <= twvw_pkg::RST_START_POS;
         cfg_ff.end_pos       <= twvw_pkg::RST_END_POS;
         cfg_ff.border_width  <= twvw_pkg::RST_BORDER_WIDTH;
         cfg_ff.symmetric     <= twvw_pkg::RST_SYMMETRIC;
         cfg_ff.vertical      <= twvw_pkg::RST_VERTICAL;
         cfg_ff.border_colour <= twvw_pkg::RST_BORDER_COLOUR;
         cfg_ff.line_width    <= twvw_pkg::RST_LINE_WIDTH;
         cfg_ff.frame_height  <= twvw_pkg::RST_FRAME_HEIGHT;
      end else if (wr_en) begin
         unique case (idx)
            twvw_pkg::REG_START_POS: begin
               cfg_ff.start_pos <= pwdata[twvw_pkg::POS_W-1:0];
            end
            twvw_pkg::REG_END_POS: begin
               cfg_ff.end_pos <= pwdata[twvw_pkg::POS_W-1:0];
            end
            twvw_pkg::REG_BORDER_WIDTH: begin
               cfg_ff.border_width <= pwdata[twvw_pkg::BORDER_W-1:0];
            end
            twvw_pkg::REG_SYMMETRIC: begin
               cfg_ff.symmetric <= pwdata[0];
            end
            twvw_pkg::REG_VERTICAL: begin
               cfg_ff.vertical <= pwdata[0];
            end
            twvw_pkg::REG_BORDER_COLOUR: begin
               cfg_ff.border_colour <= pwdata[twvw_pkg::PIX_W-1:0];
            end
            twvw_pkg::REG_LINE_WIDTH: begin
               cfg_ff.line_width <= pwdata[twvw_pkg::DIM_W-1:0];
            end
            twvw_pkg::REG_FRAME_HEIGHT: begin
               cfg_ff.frame_height <= pwdata[twvw_pkg::DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         twvw_pkg::REG_START_POS:     prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.start_pos);
         twvw_pkg::REG_END_POS:       prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.end_pos);
         twvw_pkg::REG_BORDER_WIDTH:  prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.border_width);
         twvw_pkg::REG_SYMMETRIC:     prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.symmetric);
         twvw_pkg::REG_VERTICAL:      prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.vertical);
         twvw_pkg::REG_BORDER_COLOUR: prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.border_colour);
         twvw_pkg::REG_LINE_WIDTH:    prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.line_width);
         twvw_pkg::REG_FRAME_HEIGHT:  prdata = twvw_pkg::CSR_DATA_W'(cfg_ff.frame_height);
         default:                     prdata = '0;
      endcase
   end

endmodule

FILE: hdl/twvw_setup.sv
module twvw_setup #(
   parameter int FRAC_BITS = 16
) (
   input  twvw_pkg::cfg_type          cfg,
   output logic signed [FRAC_BITS+1:0] edge_pos [4]
);

   localparam int V_W   = FRAC_BITS + 2;
   localparam int EXT_W = (V_W > twvw_pkg::POS_W) ? V_W : twvw_pkg::POS_W;
   localparam logic [EXT_W-1:0] ONE_X  = EXT_W'(1) << FRAC_BITS;
   localparam logic [EXT_W-1:0] HALF_X = EXT_W'(1) << (FRAC_BITS - 1);
   localparam logic [V_W-1:0]   ONE_V  = V_W'(1) << FRAC_BITS;

   logic [EXT_W-1:0] start_x, end_x, bw_x;
   logic [V_W-1:0]   s_clip, e_clip, b_clip;
   logic [V_W-1:0]   s_sym, e_sym, s_lo, e_hi;

   // saturate the fractions
   always_comb begin
      start_x = EXT_W'(cfg.start_pos);
      end_x   = EXT_W'(cfg.end_pos);
      bw_x    = EXT_W'(cfg.border_width);
      s_clip  = (start_x > ONE_X) ? V_W'(ONE_X) : V_W'(start_x);
      e_clip  = (end_x > ONE_X) ? V_W'(ONE_X) : V_W'(end_x);
      b_clip  = (bw_x > HALF_X) ? V_W'(HALF_X) : V_W'(bw_x);
   end

   // symmetric mode mirrors the halved start
   assign s_sym = cfg.symmetric ? (s_clip >> 1) : s_clip;
   assign e_sym = cfg.symmetric ? (ONE_V - (s_clip >> 1)) : e_clip;

   // order start and end
   assign s_lo = (s_sym > e_sym) ? e_sym : s_sym;
   assign e_hi = (s_sym > e_sym) ? s_sym : e_sym;

   // band edges as fractions
   assign edge_pos[0] = $signed(s_lo) - $signed(b_clip);
   assign edge_pos[1] = $signed(s_lo) + $signed(b_clip);
   assign edge_pos[2] = $signed(e_hi) - $signed(b_clip);
   assign edge_pos[3] = $signed(e_hi) + $signed(b_clip);

endmodule

FILE: hdl/twvw_classify.sv
module twvw_classify #(
   parameter int P_W = 32
) (
   input  logic                                vertical,
   input  logic signed [P_W-1:0]               key,
   input  logic signed [P_W-1:0]               lim [4],
   output logic [twvw_pkg::REGION_W-1:0]       region
);

   logic outer, inner;

   // row mode keeps the first limit inclusive
   assign outer = vertical ? (key <= lim[0] || key >= lim[3])
                           : (key <  lim[0] || key >= lim[3]);
   assign inner = (key > lim[1]) && (key < lim[2]);

   always_comb begin
      priority if (outer) begin
         region = twvw_pkg::REGION_B;
      end else if (inner) begin
         region = twvw_pkg::REGION_A;
      end else begin
         region = twvw_pkg::REGION_BORDER;
      end
   end

endmodule

FILE: hdl/triple_split_video_wipe_top.sv
// Three-band split-screen wipe: takes co-sited pixels of two frames in raster
// order and gives one output pixel per input beat, pixel_b in the outer bands,
// pixel_a in the middle band and the border colour in between. Throughput is
// one pixel per clock while the output is not stalled by rsp_ready; the stages
// are input register, band-limit multiply, row rounding, compare and select into
// the output register. Register writes are sampled when the first pixel of a frame
// (column and row both zero) is accepted and hold for the whole frame, so program
// the block only while it is idle. Line width and frame height of zero act as one
// and are capped at MAX_WIDTH and MAX_HEIGHT.
module triple_split_video_wipe_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  twvw_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output twvw_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [twvw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [twvw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [twvw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int N_W    = (WID_W > HGT_W) ? WID_W : HGT_W;
   localparam int V_W    = FRAC_BITS + 2;
   localparam int P_W    = N_W + 1 + V_W;
   localparam int LW_X   = (WID_W > twvw_pkg::DIM_W) ? WID_W : twvw_pkg::DIM_W;
   localparam int FH_X   = (HGT_W > twvw_pkg::DIM_W) ? HGT_W : twvw_pkg::DIM_W;
   localparam logic signed [P_W-1:0] HALF_P = P_W'(1) << (FRAC_BITS - 1);

   twvw_pkg::cfg_type cfg;

   // configuration registers
   twvw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // band edges from the live registers
   logic signed [V_W-1:0] edge_cfg [4];

   twvw_setup #(
      .FRAC_BITS (FRAC_BITS)
   ) u_setup (
      .cfg      (cfg),
      .edge_pos (edge_cfg)
   );

   // pipeline handshake, each stage fills its own bubble
   logic rdy1, rdy2, rdy3, rdy4;
   logic val1_ff, val2_ff, val3_ff, rsp_valid_ff;
   logic accept;

   assign rdy4      = !rsp_valid_ff || rsp_ready;
   assign rdy3      = !val3_ff || rdy4;
   assign rdy2      = !val2_ff || rdy3;
   assign rdy1      = !val1_ff || rdy2;
   assign req_ready = rdy1;
   assign accept    = req_valid && rdy1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val1_ff      <= 1'b0;
         val2_ff      <= 1'b0;
         val3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            val1_ff <= req_valid;
         end
         if (rdy2) begin
            val2_ff <= val1_ff;
         end
         if (rdy3) begin
            val3_ff <= val2_ff;
         end
         if (rdy4) begin
            rsp_valid_ff <= val3_ff;
         end
      end
   end

   // frame size clamp
   logic [LW_X-1:0]  lw_x;
   logic [FH_X-1:0]  fh_x;
   logic [WID_W-1:0] wid_cfg;
   logic [HGT_W-1:0] hgt_cfg;

   always_comb begin
      lw_x = LW_X'(cfg.line_width);
      fh_x = FH_X'(cfg.frame_height);
      priority if (lw_x == '0) begin
         wid_cfg = WID_W'(1);
      end else if (lw_x > LW_X'(MAX_WIDTH)) begin
         wid_cfg = WID_W'(MAX_WIDTH);
      end else begin
         wid_cfg = WID_W'(lw_x);
      end
      priority if (fh_x == '0) begin
         hgt_cfg = HGT_W'(1);
      end else if (fh_x > FH_X'(MAX_HEIGHT)) begin
         hgt_cfg = HGT_W'(MAX_HEIGHT);
      end else begin
         hgt_cfg = HGT_W'(fh_x);
      end
   end

   // raster counters, frame size latched at frame start
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WID_W-1:0] wid_ff, wid_use, col_inc;
   logic [HGT_W-1:0] hgt_ff, hgt_use, row_inc;
   logic             frame_start;

   assign frame_start = (col_ff == '0) && (row_ff == '0);
   assign wid_use     = frame_start ? wid_cfg : wid_ff;
   assign hgt_use     = frame_start ? hgt_cfg : hgt_ff;
   assign col_inc     = WID_W'(col_ff) + WID_W'(1);
   assign row_inc     = HGT_W'(row_ff) + HGT_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_inc >= wid_use) begin
         col_in = '0;
         row_in = (row_inc >= hgt_use) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_start) begin
         wid_ff <= wid_cfg;
         hgt_ff <= hgt_cfg;
      end
   end

   // stage 1: input register, band edges taken at frame start
   twvw_pkg::req_type       req1_ff;
   logic [COL_W-1:0]        col1_ff;
   logic [ROW_W-1:0]        row1_ff;
   logic                    fs1_ff;
   logic signed [V_W-1:0]   edge1_ff [4];
   logic [N_W-1:0]          n1_ff;
   logic                    vert1_ff;
   logic [twvw_pkg::PIX_W-1:0] colour1_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         req1_ff <= req_data;
         col1_ff <= col_ff;
         row1_ff <= row_ff;
         fs1_ff  <= frame_start;
      end
      if (accept && frame_start) begin
         edge1_ff   <= edge_cfg;
         n1_ff      <= cfg.vertical ? N_W'(hgt_cfg) : N_W'(wid_cfg);
         vert1_ff   <= cfg.vertical;
         colour1_ff <= cfg.border_colour;
      end
   end

   // stage 2: scale the edges by the frame size
   logic signed [N_W:0]     n1_s;
   logic signed [P_W-1:0]   prod [4];

   assign n1_s = $signed({1'b0, n1_ff});

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod[i] = n1_s * edge1_ff[i];
      end
   end

   twvw_pkg::req_type       req2_ff;
   logic [COL_W-1:0]        col2_ff;
   logic [ROW_W-1:0]        row2_ff;
   logic                    fs2_ff;
   logic signed [P_W-1:0]   prod2_ff [4];
   logic                    vert2_ff;
   logic [twvw_pkg::PIX_W-1:0] colour2_ff;

   always_ff @(posedge clock) begin
      if (rdy2 && val1_ff) begin
         req2_ff <= req1_ff;
         col2_ff <= col1_ff;
         row2_ff <= row1_ff;
         fs2_ff  <= fs1_ff;
      end
      if (rdy2 && val1_ff && fs1_ff) begin
         prod2_ff   <= prod;
         vert2_ff   <= vert1_ff;
         colour2_ff <= colour1_ff;
      end
   end

   // stage 3: row limits rounded half up, truncated toward zero
   logic signed [P_W-1:0] rnd_sum [4];
   logic        [P_W-1:0] rnd_mag [4];
   logic        [P_W-1:0] rnd_q   [4];
   logic signed [P_W-1:0] lim_in  [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rnd_sum[i] = prod2_ff[i] + HALF_P;
         rnd_mag[i] = rnd_sum[i][P_W-1] ? P_W'(-rnd_sum[i]) : P_W'(rnd_sum[i]);
         rnd_q[i]   = rnd_mag[i] >> FRAC_BITS;
         lim_in[i]  = vert2_ff ? (rnd_sum[i][P_W-1] ? -$signed(rnd_q[i]) : $signed(rnd_q[i]))
                               : prod2_ff[i];
      end
   end

   twvw_pkg::req_type       req3_ff;
   logic [COL_W-1:0]        col3_ff;
   logic [ROW_W-1:0]        row3_ff;
   logic signed [P_W-1:0]   lim3_ff [4];
   logic                    vert3_ff;
   logic [twvw_pkg::PIX_W-1:0] colour3_ff;

   always_ff @(posedge clock) begin
      if (rdy3 && val2_ff) begin
         req3_ff <= req2_ff;
         col3_ff <= col2_ff;
         row3_ff <= row2_ff;
      end
      if (rdy3 && val2_ff && fs2_ff) begin
         lim3_ff    <= lim_in;
         vert3_ff   <= vert2_ff;
         colour3_ff <= colour2_ff;
      end
   end

   // stage 4: compare position against limits, pick the pixel
   logic signed [P_W-1:0]              key3;
   logic [twvw_pkg::REGION_W-1:0]      region3;
   twvw_pkg::rsp_type                  rsp_in;
   twvw_pkg::rsp_type                  rsp_data_ff;

   assign key3 = vert3_ff ? $signed(P_W'(row3_ff))
                          : $signed(P_W'({col3_ff, {FRAC_BITS{1'b0}}}));

   twvw_classify #(
      .P_W (P_W)
   ) u_classify (
      .vertical (vert3_ff),
      .key      (key3),
      .lim      (lim3_ff),
      .region   (region3)
   );

   always_comb begin
      rsp_in.region = region3;
      unique case (region3)
         twvw_pkg::REGION_B: rsp_in.pixel_out = req3_ff.pixel_b;
         twvw_pkg::REGION_A: rsp_in.pixel_out = req3_ff.pixel_a;
         default:            rsp_in.pixel_out = colour3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4 && val3_ff) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   // column counter stays inside the latched line
   assert property (@(posedge clock) disable iff (reset)
      (col_ff != '0) |-> (WID_W'(col_ff) < wid_ff))
      else $error("column counter beyond line width");

   // row counter stays inside the latched frame
   assert property (@(posedge clock) disable iff (reset)
      (row_ff != '0) |-> (HGT_W'(row_ff) < hgt_ff))
      else $error("row counter beyond frame height");

   // limits in stage 3 are ordered for any item in flight
   assert property (@(posedge clock) disable iff (reset)
      val3_ff |-> (lim3_ff[0] <= lim3_ff[1] && lim3_ff[2] <= lim3_ff[3] &&
                   lim3_ff[0] <= lim3_ff[2]))
      else $error("band limits out of order");

   // a frame start beat on a line wider than one pixel leaves the column counter at one
   assert property (@(posedge clock) disable iff (reset)
      (accept && frame_start && wid_cfg != WID_W'(1)) |=> (col_ff == COL_W'(1)))
      else $error("counter did not advance after frame start");

   // result region is a legal code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.region == twvw_pkg::REGION_A ||
                        rsp_data_ff.region == twvw_pkg::REGION_B ||
                        rsp_data_ff.region == twvw_pkg::REGION_BORDER))
      else $error("illegal region code");
`endif

endmodule
